>>> src/dss_pkg.sv
// Shared types, stage numbering and fixed-point helpers for the diffusion stencil.
package dss_pkg;

  // Pipeline stage numbering (register stages)
  localparam int unsigned DivStages  = 32;
  localparam int unsigned DivFirst   = 2;
  localparam int unsigned RecipStage = DivFirst + DivStages - 1;
  localparam int unsigned BackStages = 5;
  localparam int unsigned OutStage   = RecipStage + BackStages;
  localparam int unsigned NumStages  = OutStage + 1;

  localparam int unsigned InBits  = 360;
  localparam int unsigned OutBits = 256;

  // Numerators of the x-spacing reciprocals
  localparam logic [63:0] NumTwo = 64'd1 << 49;
  localparam logic [63:0] NumOne = 64'd1 << 48;

  localparam logic signed [63:0] QMax = 64'sd2147483647;
  localparam logic signed [63:0] QMin = -64'sd2147483648;

  typedef enum logic {
    REG_Y_FACTOR = 1'b0,
    REG_Z_FACTOR = 1'b1
  } reg_idx_e;

  // One input beat, unpacked
  typedef struct packed {
    logic [6:0]        sink_mask;
    logic [30:0]       step_right;
    logic [30:0]       step_left;
    logic [31:0]       coeff_delta;
    logic [30:0]       coeff_mid;
    logic [6:0][31:0]  conc;
  } in_beat_t;

  // Per-item data that rides along the pipeline
  typedef struct packed {
    logic [6:0]        mask;
    logic [30:0]       coeff;
    logic [31:0]       delta;
    logic [6:0][31:0]  conc;
  } side_t;

  // One result beat
  typedef struct packed {
    logic [31:0] partial_back;
    logic [31:0] partial_front;
    logic [31:0] partial_top;
    logic [31:0] partial_bottom;
    logic [31:0] partial_right;
    logic [31:0] partial_left;
    logic [31:0] partial_mid;
    logic [31:0] rate;
  } out_beat_t;

  // Round half up and drop sixteen fraction bits
  function automatic logic signed [63:0] qrnd(input logic signed [63:0] p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > QMax) r = 32'h7FFF_FFFF;
    else if (v < QMin) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // Signed 32 by 32 product
  function automatic logic signed [63:0] smul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return 64'(a) * 64'(b);
  endfunction

  // Zero-extend an unsigned 31-bit value to signed 32 bits
  function automatic logic signed [31:0] u31(input logic [30:0] v);
    return $signed({1'b0, v});
  endfunction

endpackage

>>> src/diffusion_seven_point_stencil.sv
// Top level: seven-point diffusion stencil with handshake, registers and pipeline control.
//
//  channel  | direction | handshake                 | payload
//  s_axis   | in        | tvalid / tready           | tdata 360 bits: one grid point
//  m_axis   | out       | tvalid / tready           | tdata 256 bits: rate and partials
//  apb      | in        | psel / penable / pready   | y_factor at 0x0, z_factor at 0x4
//
// One beat per cycle in and out while the output is not stalled; 39 register stages in all,
// most of them the 32-stage reciprocal dividers, which form one quotient bit per stage after
// the first.
// Each stage holds its own valid bit and loads whenever it is empty or the next one
// moves, so bubbles close up under a stalled output and nothing is lost or repeated.
// Reset clears the valid bits and sets both factors to 1.0.
module diffusion_seven_point_stencil import dss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // conc_mid, conc_left, conc_right, conc_bottom, conc_top, conc_front, conc_back,
  // coeff_mid, coeff_delta, step_left, step_right, sink_mask, zero pad
  input  logic [InBits-1:0]  s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // rate, partial_mid, partial_left, partial_right, partial_bottom, partial_top,
  // partial_front, partial_back
  output logic [OutBits-1:0] m_axis_tdata,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Configuration registers
  logic [30:0] y_factor_q, z_factor_q;
  logic        wr_en;
  reg_idx_e    wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_factor_q <= 31'd65536;
      z_factor_q <= 31'd65536;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_Y_FACTOR: y_factor_q <= pwdata[30:0];
        REG_Z_FACTOR: z_factor_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_Y_FACTOR: prdata = {1'b0, y_factor_q};
      REG_Z_FACTOR: prdata = {1'b0, z_factor_q};
      default:      prdata = '0;
    endcase
  end

  // Stage valid bits and per-stage load enables
  logic [NumStages-1:0] valid_q, en;

  always_comb begin
    en[OutStage] = !valid_q[OutStage] || m_axis_tready;
    for (int i = OutStage - 1; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= s_axis_tvalid;
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) valid_q[i] <= valid_q[i-1];
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = valid_q[OutStage];

  // Front end
  in_beat_t    beat;
  side_t       side0;
  logic [63:0] den_ls, den_rs, den_lr, den_ss;

  assign beat = in_beat_t'(s_axis_tdata[$bits(in_beat_t)-1:0]);

  dss_front u_front (
    .clk_i    (clk_i),
    .en_i     (en[1:0]),
    .beat_i   (beat),
    .side_o   (side0),
    .den_ls_o (den_ls),
    .den_rs_o (den_rs),
    .den_lr_o (den_lr),
    .den_ss_o (den_ss)
  );

  // Carry the item data alongside the dividers and into the back end
  side_t side_q [1:OutStage-1];

  always_ff @(posedge clk_i) begin
    if (en[1]) side_q[1] <= side0;
    for (int i = 2; i < OutStage; i++) begin
      if (en[i]) side_q[i] <= side_q[i-1];
    end
  end

  // Reciprocal dividers
  logic [30:0] cl, cr, cm, g;

  dss_recip u_recip_l (
    .clk_i (clk_i), .en_i (en[RecipStage:DivFirst]),
    .num_i (NumTwo), .den_i (den_ls), .recip_o (cl)
  );
  dss_recip u_recip_r (
    .clk_i (clk_i), .en_i (en[RecipStage:DivFirst]),
    .num_i (NumTwo), .den_i (den_rs), .recip_o (cr)
  );
  dss_recip u_recip_m (
    .clk_i (clk_i), .en_i (en[RecipStage:DivFirst]),
    .num_i (NumOne), .den_i (den_lr), .recip_o (cm)
  );
  dss_recip u_recip_g (
    .clk_i (clk_i), .en_i (en[RecipStage:DivFirst]),
    .num_i (NumOne), .den_i (den_ss), .recip_o (g)
  );

  // Back end
  out_beat_t res;

  dss_back u_back (
    .clk_i      (clk_i),
    .en_i       (en[OutStage:RecipStage+1]),
    .y_factor_i (y_factor_q),
    .z_factor_i (z_factor_q),
    .cl_i       (cl),
    .cr_i       (cr),
    .cm_i       (cm),
    .g_i        (g),
    .side_p1_i  (side_q[RecipStage]),
    .side_p2_i  (side_q[RecipStage+1]),
    .side_p4_i  (side_q[RecipStage+3]),
    .side_p5_i  (side_q[RecipStage+4]),
    .res_o      (res)
  );

  assign m_axis_tdata = res;

  // Input backs up only when every stage is full and the output is stalled
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && valid_q[0]))
    else $error("input stalled with room in the pipeline");

  // A stalled stage ahead of the output stage sits behind a full, stalled output stage
  a_stall_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[OutStage-1] && !en[OutStage-1]) |-> (valid_q[OutStage] && !m_axis_tready))
    else $error("stage stalled without a stalled successor");

  // A held result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A write to the y factor register lands
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && wr_idx == REG_Y_FACTOR) |=> (y_factor_q == $past(pwdata[30:0])))
    else $error("y factor write lost");

endmodule

>>> src/dss_front.sv
// Input capture, masking and the divisor products of the x-spacing reciprocals.
module dss_front import dss_pkg::*; (
  input  logic        clk_i,
  input  logic [1:0]  en_i,
  input  in_beat_t    beat_i,
  output side_t       side_o,
  output logic [63:0] den_ls_o,
  output logic [63:0] den_rs_o,
  output logic [63:0] den_lr_o,
  output logic [63:0] den_ss_o
);

  side_t       side_d;
  logic [30:0] hl_q, hr_q;
  logic [31:0] s_q;

  // Zero the concentrations of inactive points, the mid point included
  always_comb begin
    side_d.mask  = beat_i.sink_mask;
    side_d.coeff = beat_i.coeff_mid;
    side_d.delta = beat_i.coeff_delta;
    for (int i = 0; i < 7; i++) begin
      side_d.conc[i] = beat_i.sink_mask[i] ? beat_i.conc[i] : 32'd0;
    end
  end

  // Stage 0: capture and sum the spacings
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      side_o <= side_d;
      hl_q   <= beat_i.step_left;
      hr_q   <= beat_i.step_right;
      s_q    <= {1'b0, beat_i.step_left} + {1'b0, beat_i.step_right};
    end
  end

  // Stage 1: divisor products
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      den_ls_o <= 64'(hl_q) * 64'(s_q);
      den_rs_o <= 64'(hr_q) * 64'(s_q);
      den_lr_o <= 64'(hl_q) * 64'(hr_q);
      den_ss_o <= 64'(s_q) * 64'(s_q);
    end
  end

endmodule

>>> src/dss_recip.sv
// Pipelined rounded reciprocal: one quotient bit per stage after the first, clamped to 31 bits.
module dss_recip import dss_pkg::*; (
  input  logic                 clk_i,
  input  logic [DivStages-1:0] en_i,
  input  logic [63:0]          num_i,
  input  logic [63:0]          den_i,
  output logic [30:0]          recip_o
);

  localparam int unsigned QBits = DivStages - 1;

  logic [63:0]      rem_q [DivStages];
  logic [63:0]      den_q [DivStages];
  logic [QBits-1:0] quo_q [DivStages];
  logic             sat_q [DivStages];

  logic [63:0]       n_d;
  logic              sat_d;
  logic [QBits+63:0] trial [DivStages];
  logic              ge    [DivStages];

  // Add half the divisor for rounding; flag quotients past 31 bits
  always_comb begin
    n_d   = num_i + (den_i >> 1);
    sat_d = {{QBits{1'b0}}, n_d} >= {den_i, {QBits{1'b0}}};
  end

  // Trial subtraction for each quotient bit
  always_comb begin
    trial[0] = '0;
    ge[0]    = 1'b0;
    for (int j = 1; j < DivStages; j++) begin
      trial[j] = {{QBits{1'b0}}, den_q[j-1]} << (QBits - j);
      ge[j]    = {{QBits{1'b0}}, rem_q[j-1]} >= trial[j];
    end
  end

  // Advance the divider stages
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= n_d;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      sat_q[0] <= sat_d;
    end
    for (int j = 1; j < DivStages; j++) begin
      if (en_i[j]) begin
        den_q[j] <= den_q[j-1];
        sat_q[j] <= sat_q[j-1];
        rem_q[j] <= ge[j] ? rem_q[j-1] - trial[j][63:0] : rem_q[j-1];
        quo_q[j] <= quo_q[j-1] | (QBits'(ge[j]) << (QBits - j));
      end
    end
  end

  assign recip_o = sat_q[DivStages-1] ? '1 : quo_q[DivStages-1];

endmodule

>>> src/dss_back.sv
// Stencil sums, Jacobian partials, saturation and masking over five stages.
module dss_back import dss_pkg::*; (
  input  logic                  clk_i,
  input  logic [BackStages-1:0] en_i,
  input  logic [30:0]           y_factor_i,
  input  logic [30:0]           z_factor_i,
  input  logic [30:0]           cl_i,
  input  logic [30:0]           cr_i,
  input  logic [30:0]           cm_i,
  input  logic [30:0]           g_i,
  input  side_t                 side_p1_i,
  input  side_t                 side_p2_i,
  input  side_t                 side_p4_i,
  input  side_t                 side_p5_i,
  output out_beat_t             res_o
);

  logic signed [31:0] sy, sz;
  assign sy = u31(y_factor_i);
  assign sz = u31(z_factor_i);

  // Stage P1 products
  logic signed [63:0] m_cl_c1_q, m_cr_c2_q, m_cm_c0_q;
  logic signed [63:0] m_y3_q, m_y4_q, m_y0_q, m_z5_q, m_z6_q, m_z0_q;
  logic signed [63:0] m_dg_q, m_dcl_q, m_dcr_q, m_dy_q, m_dz_q;
  logic [30:0]        sumc_q;
  logic [32:0]        sum_d;
  logic signed [31:0] d1;

  assign d1    = u31(side_p1_i.coeff);
  assign sum_d = 33'(cm_i) + 33'(y_factor_i) + 33'(z_factor_i);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      m_cl_c1_q <= smul(u31(cl_i), $signed(side_p1_i.conc[1]));
      m_cr_c2_q <= smul(u31(cr_i), $signed(side_p1_i.conc[2]));
      m_cm_c0_q <= smul(u31(cm_i), $signed(side_p1_i.conc[0]));
      m_y3_q    <= smul(sy, $signed(side_p1_i.conc[3]));
      m_y4_q    <= smul(sy, $signed(side_p1_i.conc[4]));
      m_y0_q    <= smul(sy, $signed(side_p1_i.conc[0]));
      m_z5_q    <= smul(sz, $signed(side_p1_i.conc[5]));
      m_z6_q    <= smul(sz, $signed(side_p1_i.conc[6]));
      m_z0_q    <= smul(sz, $signed(side_p1_i.conc[0]));
      m_dg_q    <= smul($signed(side_p1_i.delta), u31(g_i));
      m_dcl_q   <= smul(d1, u31(cl_i));
      m_dcr_q   <= smul(d1, u31(cr_i));
      m_dy_q    <= smul(d1, sy);
      m_dz_q    <= smul(d1, sz);
      sumc_q    <= sum_d[32:31] != 2'b00 ? '1 : sum_d[30:0];
    end
  end

  // Stage P2: round, per-axis sums, coefficient slope
  logic signed [63:0] bx_q, by_q, bz_q, qdcl_q, qdcr_q, m_ds_q;
  logic [31:0]        k_q, p_y_q, p_z_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      bx_q   <= qrnd(m_cl_c1_q) + qrnd(m_cr_c2_q) - (qrnd(m_cm_c0_q) <<< 1);
      by_q   <= qrnd(m_y3_q) + qrnd(m_y4_q) - (qrnd(m_y0_q) <<< 1);
      bz_q   <= qrnd(m_z5_q) + qrnd(m_z6_q) - (qrnd(m_z0_q) <<< 1);
      k_q    <= sat32(qrnd(m_dg_q));
      qdcl_q <= qrnd(m_dcl_q);
      qdcr_q <= qrnd(m_dcr_q);
      p_y_q  <= sat32(qrnd(m_dy_q));
      p_z_q  <= sat32(qrnd(m_dz_q));
      m_ds_q <= smul(u31(side_p2_i.coeff), u31(sumc_q));
    end
  end

  // Stage P3: laplacian and x partials
  logic [31:0] b_q, k3_q, pm_q, pl_q, pr_q, p_y3_q, p_z3_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      b_q    <= sat32(bx_q + by_q + bz_q);
      pm_q   <= sat32(-(qrnd(m_ds_q) <<< 1));
      pl_q   <= sat32(qdcl_q - 64'($signed(k_q)));
      pr_q   <= sat32(qdcr_q + 64'($signed(k_q)));
      k3_q   <= k_q;
      p_y3_q <= p_y_q;
      p_z3_q <= p_z_q;
    end
  end

  // Stage P4: rate products
  logic signed [63:0] m_db_q, m_kc2_q, m_kc1_q;
  logic [31:0]        pm4_q, pl4_q, pr4_q, p_y4_q, p_z4_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      m_db_q  <= smul(u31(side_p4_i.coeff), $signed(b_q));
      m_kc2_q <= smul($signed(k3_q), $signed(side_p4_i.conc[2]));
      m_kc1_q <= smul($signed(k3_q), $signed(side_p4_i.conc[1]));
      pm4_q   <= pm_q;
      pl4_q   <= pl_q;
      pr4_q   <= pr_q;
      p_y4_q  <= p_y3_q;
      p_z4_q  <= p_z3_q;
    end
  end

  // Stage P5: rate and masked partials into the output register
  logic [6:0] mk;
  assign mk = side_p5_i.mask;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      res_o.rate           <= sat32(qrnd(m_db_q) + qrnd(m_kc2_q) - qrnd(m_kc1_q));
      res_o.partial_mid    <= mk[0] ? pm4_q  : 32'd0;
      res_o.partial_left   <= mk[1] ? pl4_q  : 32'd0;
      res_o.partial_right  <= mk[2] ? pr4_q  : 32'd0;
      res_o.partial_bottom <= mk[3] ? p_y4_q : 32'd0;
      res_o.partial_top    <= mk[4] ? p_y4_q : 32'd0;
      res_o.partial_front  <= mk[5] ? p_z4_q : 32'd0;
      res_o.partial_back   <= mk[6] ? p_z4_q : 32'd0;
    end
  end

endmodule
